[rtl/core/pfp_pkg.sv]
// Package of the per-flow token bucket policer.
// Holds table size, operation and status codes, and the shared types.
// Used by pfp_cam and per_flow_token_bucket_policer.
package pfp_pkg;

    localparam int NUM_FLOWS = 16;
    localparam int IDX_W     = (NUM_FLOWS > 1) ? $clog2(NUM_FLOWS) : 1;
    localparam int BYTE_SHIFT = 3;

    localparam logic [1:0] OP_PACKET   = 2'd0;
    localparam logic [1:0] OP_TICK     = 2'd1;
    localparam logic [1:0] OP_ACTIVATE = 2'd2;

    localparam logic [1:0] ST_FORWARD  = 2'd0;
    localparam logic [1:0] ST_DROP     = 2'd1;
    localparam logic [1:0] ST_ACTIVE   = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    typedef struct packed {
        logic [31:0] bucket;
        logic [31:0] tokens;
        logic [31:0] period;
        logic [31:0] countdown;
        logic [7:0]  prio;
    } t_entry;

    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] hit_idx;
        logic             free;
        logic [IDX_W-1:0] free_idx;
    } t_cam_res;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        logic [15:0]      flow;
    } t_cam_wr;

endpackage

[rtl/core/pfp_cam.sv]
// Flow id match table: valid bits and flow ids in flip-flops.
// Gives the matching entry and the lowest free entry for one key.
// Depends on pfp_pkg.
module pfp_cam import pfp_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [15:0]          i_key,
    input  t_cam_wr              i_wr,
    output t_cam_res             o_res,
    output logic [NUM_FLOWS-1:0] o_vld
);

    logic [NUM_FLOWS-1:0] r_vld;
    logic [15:0]          r_flow [NUM_FLOWS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr.en) begin
            r_vld[i_wr.idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_flow[i_wr.idx] <= i_wr.flow;
        end
    end

    always_comb begin
        o_res = '0;
        for (int i = NUM_FLOWS - 1; i >= 0; i--) begin
            if (r_vld[i] && (r_flow[i] == i_key)) begin
                o_res.hit     = 1'b1;
                o_res.hit_idx = IDX_W'(i);
            end
            if (!r_vld[i]) begin
                o_res.free     = 1'b1;
                o_res.free_idx = IDX_W'(i);
            end
        end
    end

    assign o_vld = r_vld;

endmodule

[rtl/core/per_flow_token_bucket_policer.sv]
// Top level of the per-flow token bucket policer.
// Rule state sits in a synchronous memory with a registered read; flow ids match in pfp_cam.
// Depends on pfp_pkg and pfp_cam.
//
// Channel   Direction  Handshake           Payload
// input     in         i_valid / o_stall   i_op, i_flow_id, i_packet_bytes, ...
// result    out        o_valid / i_stall   o_status, o_matched, o_priority_res
//
// A packet or an activate item is accepted in S_IDLE; a packet's memory read returns in S_RD,
// an activate looks up pfp_cam in S_ACT, and the result is loaded into the output register.
// A tick walks the rule memory one entry a cycle in S_TICK, then writes back the last in S_TDRN.
// While a finished result waits under i_stall, the next item is still accepted;
// it waits before its own result until the output register frees.
// Reset clears the CAM valid bits but not the rule memory; no clearing pass is needed.
module per_flow_token_bucket_policer import pfp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_op,
    input  logic [15:0] i_flow_id,
    input  logic [15:0] i_packet_bytes,
    input  logic [7:0]  i_packet_priority,
    input  logic [31:0] i_bucket_bits,
    input  logic [31:0] i_interval_ticks,
    input  logic [7:0]  i_rule_priority,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic        o_matched,
    output logic [7:0]  o_priority_res
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_RD   = 5'b00010,
        S_ACT  = 5'b00100,
        S_TICK = 5'b01000,
        S_TDRN = 5'b10000
    } t_state;

    t_state r_state, n_state;

    t_entry mem [NUM_FLOWS];
    t_entry r_rd;

    logic             w_re;
    logic [IDX_W-1:0] w_raddr;
    logic             w_we;
    logic [IDX_W-1:0] w_waddr;
    t_entry           w_wdata;

    logic [15:0] r_flow;
    logic [15:0] r_bytes;
    logic [7:0]  r_pprio;
    logic [31:0] r_bucket;
    logic [31:0] r_period;
    logic [7:0]  r_rprio;
    logic        r_hit;
    logic [IDX_W-1:0] r_idx;

    logic [IDX_W-1:0] r_cnt;
    logic             r_wb_vld;
    logic [IDX_W-1:0] r_wb_idx;

    logic        r_o_valid;
    logic [1:0]  r_status;
    logic        r_matched;
    logic [7:0]  r_prio_res;

    t_cam_res             w_cam;
    t_cam_wr              w_cam_wr;
    logic [NUM_FLOWS-1:0] w_vld;
    logic [15:0]          w_key;

    logic        w_acc;
    logic        w_slot;
    logic        w_load;
    logic [31:0] w_need;
    logic        w_fwd;
    logic [1:0]  w_status;
    logic        w_matched;
    logic [7:0]  w_prio_res;
    logic        w_last;

    assign w_acc   = i_valid && (r_state == S_IDLE);
    assign o_stall = (r_state != S_IDLE);
    assign w_slot  = !r_o_valid || !i_stall;
    assign w_key   = (r_state == S_IDLE) ? i_flow_id : r_flow;
    assign w_need  = {16'd0, r_bytes} << BYTE_SHIFT;
    assign w_fwd   = (r_rd.tokens >= w_need);
    assign w_last  = (r_cnt == IDX_W'(NUM_FLOWS - 1));

    pfp_cam u_cam (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_key   (w_key),
        .i_wr    (w_cam_wr),
        .o_res   (w_cam),
        .o_vld   (w_vld)
    );

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rd <= mem[w_raddr];
        end
    end

    always_comb begin
        w_re    = 1'b0;
        w_raddr = w_cam.hit_idx;
        if (w_acc && (i_op == OP_PACKET)) begin
            w_re = w_cam.hit;
        end else if (r_state == S_TICK) begin
            w_re    = 1'b1;
            w_raddr = r_cnt;
        end
    end

    always_comb begin
        w_we      = 1'b0;
        w_waddr   = r_idx;
        w_wdata   = r_rd;
        w_cam_wr  = '0;
        w_load    = 1'b0;
        w_status  = ST_FORWARD;
        w_matched = 1'b0;
        w_prio_res = r_pprio;
        case (r_state)
            S_RD: begin
                w_load = w_slot;
                if (r_hit) begin
                    w_matched  = 1'b1;
                    w_prio_res = r_rd.prio;
                    w_status   = w_fwd ? ST_FORWARD : ST_DROP;
                    w_we       = w_slot && w_fwd;
                    w_wdata.tokens = r_rd.tokens - w_need;
                end
            end
            S_ACT: begin
                w_load     = w_slot;
                w_prio_res = 8'd0;
                w_waddr    = w_cam.hit ? w_cam.hit_idx : w_cam.free_idx;
                w_status   = (w_cam.hit || w_cam.free) ? ST_ACTIVE : ST_FULL;
                w_we       = w_slot && (w_cam.hit || w_cam.free);
                w_wdata.bucket    = r_bucket;
                w_wdata.tokens    = r_bucket;
                w_wdata.period    = r_period;
                w_wdata.countdown = r_period;
                w_wdata.prio      = r_rprio;
                w_cam_wr.en   = w_we;
                w_cam_wr.idx  = w_waddr;
                w_cam_wr.flow = r_flow;
            end
            S_TICK, S_TDRN: begin
                w_waddr = r_wb_idx;
                w_we    = r_wb_vld && w_vld[r_wb_idx];
                if (r_rd.countdown <= 32'd1) begin
                    w_wdata.tokens    = r_rd.bucket;
                    w_wdata.countdown = r_rd.period;
                end else begin
                    w_wdata.countdown = r_rd.countdown - 32'd1;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    case (i_op)
                        OP_PACKET:   n_state = S_RD;
                        OP_TICK:     n_state = S_TICK;
                        OP_ACTIVATE: n_state = S_ACT;
                        default:     n_state = S_IDLE;
                    endcase
                end
            end
            S_RD, S_ACT: begin
                if (w_slot) begin
                    n_state = S_IDLE;
                end
            end
            S_TICK: begin
                if (w_last) begin
                    n_state = S_TDRN;
                end
            end
            S_TDRN:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
            r_wb_vld  <= 1'b0;
            r_cnt     <= '0;
        end else begin
            r_state   <= n_state;
            r_o_valid <= w_load || (r_o_valid && i_stall);
            r_wb_vld  <= (r_state == S_TICK);
            if (r_state == S_TICK) begin
                r_cnt <= w_last ? '0 : r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_wb_idx <= r_cnt;
        if (w_acc) begin
            r_flow   <= i_flow_id;
            r_bytes  <= i_packet_bytes;
            r_pprio  <= i_packet_priority;
            r_bucket <= i_bucket_bits;
            r_period <= (i_interval_ticks == 32'd0) ? 32'd1 : i_interval_ticks;
            r_rprio  <= i_rule_priority;
            r_hit    <= w_cam.hit;
            r_idx    <= w_cam.hit_idx;
        end
        if (w_load) begin
            r_status   <= w_status;
            r_matched  <= w_matched;
            r_prio_res <= w_prio_res;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_status       = r_status;
    assign o_matched      = r_matched;
    assign o_priority_res = r_prio_res;

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !w_we)
        else $error("Rule memory written while idle.");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && i_stall) |=> (r_o_valid && $stable(r_status) && $stable(r_prio_res)))
        else $error("Waiting result was overwritten.");

    a_tick_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TICK && !w_last) |=> (r_cnt == $past(r_cnt) + 1'b1))
        else $error("Tick walk skipped an entry.");

    a_drain_after_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TDRN) |-> r_wb_vld)
        else $error("Tick drain without a pending write-back.");

endmodule

[tb/sv/tb_per_flow_token_bucket_policer.sv]
`timescale 1ns / 1ps
// Self-checking testbench of per_flow_token_bucket_policer, with its own model of the rule table.
// Random valid/stall gaps on both channels, plus one long hold on the result side.
// Depends on pfp_pkg and the per_flow_token_bucket_policer RTL.
module tb_per_flow_token_bucket_policer;
    import pfp_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int unsigned N_RANDOM = 2000;
    localparam int unsigned POOL_N = 18;

    typedef struct {
        logic [1:0]  op;
        logic [15:0] flow;
        logic [15:0] bytes;
        logic [7:0]  pprio;
        logic [31:0] bucket;
        logic [31:0] interval;
        logic [7:0]  rprio;
        int unsigned gap;
    } policer_item_t;

    typedef struct {
        logic [1:0] status;
        logic       matched;
        logic [7:0] prio;
    } verdict_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_op = OP_PACKET;
    logic [15:0] i_flow_id = '0;
    logic [15:0] i_packet_bytes = '0;
    logic [7:0]  i_packet_priority = '0;
    logic [31:0] i_bucket_bits = '0;
    logic [31:0] i_interval_ticks = '0;
    logic [7:0]  i_rule_priority = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [1:0]  o_status;
    logic        o_matched;
    logic [7:0]  o_priority_res;

    policer_item_t offer_q[$];
    verdict_t      verdict_q[$];

    logic        tbl_valid [NUM_FLOWS];
    logic [15:0] tbl_flow [NUM_FLOWS];
    logic [31:0] tbl_bucket [NUM_FLOWS];
    logic [31:0] tbl_tokens [NUM_FLOWS];
    logic [31:0] tbl_period [NUM_FLOWS];
    logic [31:0] tbl_countdown [NUM_FLOWS];
    logic [7:0]  tbl_prio [NUM_FLOWS];

    int unsigned n_total = 0;
    int unsigned n_sent = 0;
    int unsigned n_results = 0;
    int unsigned n_errors = 0;
    int unsigned gap_cnt = 0;
    int unsigned wait_cnt = 0;
    int unsigned hold_cnt = 0;
    int unsigned hold_done = 0;

    per_flow_token_bucket_policer u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_op              (i_op),
        .i_flow_id         (i_flow_id),
        .i_packet_bytes    (i_packet_bytes),
        .i_packet_priority (i_packet_priority),
        .i_bucket_bits     (i_bucket_bits),
        .i_interval_ticks  (i_interval_ticks),
        .i_rule_priority   (i_rule_priority),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_status          (o_status),
        .o_matched         (o_matched),
        .o_priority_res    (o_priority_res)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic add_item(input logic [1:0] op, input logic [15:0] flow,
                            input logic [15:0] bytes, input logic [7:0] pprio,
                            input logic [31:0] bucket, input logic [31:0] interval,
                            input logic [7:0] rprio);
        policer_item_t it;
        it.op = op;
        it.flow = flow;
        it.bytes = bytes;
        it.pprio = pprio;
        it.bucket = bucket;
        it.interval = interval;
        it.rprio = rprio;
        it.gap = (((offer_q.size() / 64) % 3) == 1) ? 0 : $urandom_range(0, 9);
        offer_q.push_back(it);
    endtask

    task automatic predict_verdict(input policer_item_t it, output bit produces,
                                   output verdict_t v);
        int          k;
        logic [31:0] need;
        logic [31:0] per;
        k = -1;
        produces = 1'b0;
        v = '{status: ST_FORWARD, matched: 1'b0, prio: 8'd0};
        if (it.op == OP_PACKET || it.op == OP_ACTIVATE) begin
            for (int i = NUM_FLOWS - 1; i >= 0; i--) begin
                if (tbl_valid[i] && tbl_flow[i] == it.flow) k = i;
            end
        end
        case (it.op)
            OP_PACKET: begin
                produces = 1'b1;
                if (k < 0) begin
                    v.prio = it.pprio;
                end else begin
                    need = {13'd0, it.bytes, 3'd0};
                    v.matched = 1'b1;
                    v.prio = tbl_prio[k];
                    if (tbl_tokens[k] >= need) begin
                        tbl_tokens[k] = tbl_tokens[k] - need;
                    end else begin
                        v.status = ST_DROP;
                    end
                end
            end
            OP_TICK: begin
                for (int i = 0; i < NUM_FLOWS; i++) begin
                    if (tbl_valid[i]) begin
                        if (tbl_countdown[i] <= 32'd1) begin
                            tbl_tokens[i] = tbl_bucket[i];
                            tbl_countdown[i] = tbl_period[i];
                        end else begin
                            tbl_countdown[i] = tbl_countdown[i] - 32'd1;
                        end
                    end
                end
            end
            OP_ACTIVATE: begin
                produces = 1'b1;
                if (k < 0) begin
                    for (int i = NUM_FLOWS - 1; i >= 0; i--) begin
                        if (!tbl_valid[i]) k = i;
                    end
                end
                if (k < 0) begin
                    v.status = ST_FULL;
                end else begin
                    per = (it.interval == 32'd0) ? 32'd1 : it.interval;
                    tbl_valid[k] = 1'b1;
                    tbl_flow[k] = it.flow;
                    tbl_bucket[k] = it.bucket;
                    tbl_tokens[k] = it.bucket;
                    tbl_period[k] = per;
                    tbl_countdown[k] = per;
                    tbl_prio[k] = it.rprio;
                    v.status = ST_ACTIVE;
                end
            end
            default: begin
            end
        endcase
    endtask

    always @(posedge i_clk) begin : tx_side
        policer_item_t it;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            gap_cnt <= 0;
        end else begin
            if (i_valid && !o_stall) n_sent <= n_sent + 1;
            if (!i_valid || !o_stall) begin
                if (gap_cnt != 0) begin
                    i_valid <= 1'b0;
                    gap_cnt <= gap_cnt - 1;
                end else if (offer_q.size() != 0) begin
                    it = offer_q.pop_front();
                    i_op <= it.op;
                    i_flow_id <= it.flow;
                    i_packet_bytes <= it.bytes;
                    i_packet_priority <= it.pprio;
                    i_bucket_bits <= it.bucket;
                    i_interval_ticks <= it.interval;
                    i_rule_priority <= it.rprio;
                    i_valid <= 1'b1;
                    gap_cnt <= it.gap;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : rx_side
        int unsigned w;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            wait_cnt <= 0;
        end else if (o_valid && !i_stall) begin
            w = (((n_results / 64) % 3) == 1) ? 0 : $urandom_range(0, 9);
            wait_cnt <= w;
            i_stall <= (w != 0) || (hold_cnt != 0);
        end else if (wait_cnt != 0) begin
            wait_cnt <= wait_cnt - 1;
            i_stall <= (wait_cnt > 1) || (hold_cnt != 0);
        end else begin
            i_stall <= (hold_cnt != 0);
        end
    end

    always @(posedge i_clk) begin : rx_hold
        if (hold_done == 0 && n_results == 300) begin
            hold_cnt <= 400;
            hold_done <= 1;
        end else if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
        end
    end

    always @(posedge i_clk) begin : scoreboard
        policer_item_t cur;
        verdict_t      v;
        verdict_t      exp_v;
        bit            produces;
        if (i_rst_n && o_valid && !i_stall) begin
            n_results <= n_results + 1;
            if (verdict_q.size() == 0) begin
                $error("result with no expectation pending: status %0d", o_status);
                n_errors = n_errors + 1;
            end else begin
                exp_v = verdict_q.pop_front();
                if (o_status !== exp_v.status) begin
                    $error("status: expected %0d, actual %0d", exp_v.status, o_status);
                    n_errors = n_errors + 1;
                end
                if (o_matched !== exp_v.matched) begin
                    $error("matched: expected %0d, actual %0d", exp_v.matched, o_matched);
                    n_errors = n_errors + 1;
                end
                if (o_priority_res !== exp_v.prio) begin
                    $error("priority_res: expected %0d, actual %0d", exp_v.prio,
                           o_priority_res);
                    n_errors = n_errors + 1;
                end
            end
        end
        if (i_rst_n && i_valid && !o_stall) begin
            cur.op = i_op;
            cur.flow = i_flow_id;
            cur.bytes = i_packet_bytes;
            cur.pprio = i_packet_priority;
            cur.bucket = i_bucket_bits;
            cur.interval = i_interval_ticks;
            cur.rprio = i_rule_priority;
            cur.gap = 0;
            predict_verdict(cur, produces, v);
            if (produces) verdict_q.push_back(v);
        end
    end

    initial begin : run_ctl
        logic [15:0] pool [POOL_N];
        int unsigned n_made;
        int unsigned r;
        int unsigned sel;
        logic [15:0] flow;
        logic [15:0] bytes;
        logic [31:0] bucket;
        logic [31:0] interval;
        for (int i = 0; i < NUM_FLOWS; i++) begin
            tbl_valid[i] = 1'b0;
            tbl_flow[i] = '0;
            tbl_bucket[i] = '0;
            tbl_tokens[i] = '0;
            tbl_period[i] = '0;
            tbl_countdown[i] = '0;
            tbl_prio[i] = '0;
        end
        pool[0] = 16'h0000;
        pool[1] = 16'hFFFF;
        for (int i = 2; i < POOL_N; i++) pool[i] = {8'($urandom_range(0, 255)), 8'(i)};

        // Largest and empty buckets, zero interval, zero-byte and unmatched packets, a tick and an unused op code.
        add_item(OP_ACTIVATE, 16'h0000, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 32'd0, 8'hFF);
        add_item(OP_ACTIVATE, 16'hFFFF, 16'h0000, 8'h00, 32'd0, 32'hFFFF_FFFF, 8'h00);
        add_item(OP_PACKET, 16'h0000, 16'hFFFF, 8'h00, 32'd0, 32'd0, 8'h00);
        add_item(OP_PACKET, 16'hFFFF, 16'h0000, 8'hFF, 32'hFFFF_FFFF, 32'd0, 8'hFF);
        add_item(OP_PACKET, 16'hFFFF, 16'h0001, 8'hFF, 32'd0, 32'd0, 8'h00);
        add_item(OP_PACKET, 16'h1234, 16'hFFFF, 8'hFF, 32'd0, 32'd0, 8'h00);
        add_item(OP_PACKET, 16'h1234, 16'h0000, 8'h00, 32'd0, 32'd0, 8'hFF);
        add_item(OP_TICK, 16'hFFFF, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
        add_item(OP_UNUSED, 16'hFFFF, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
        // Replacement of an existing flow, then draining and periodic refill.
        add_item(OP_ACTIVATE, 16'h0000, 16'h0000, 8'h00, 32'd16, 32'd2, 8'h5A);
        add_item(OP_PACKET, 16'h0000, 16'h0002, 8'h11, 32'd0, 32'd0, 8'h00);
        add_item(OP_PACKET, 16'h0000, 16'h0001, 8'h22, 32'd0, 32'd0, 8'h00);
        add_item(OP_TICK, 16'h0000, 16'h0000, 8'h00, 32'd0, 32'd0, 8'h00);
        add_item(OP_PACKET, 16'h0000, 16'h0001, 8'h33, 32'd0, 32'd0, 8'h00);
        add_item(OP_TICK, 16'h0000, 16'h0000, 8'h00, 32'd0, 32'd0, 8'h00);
        add_item(OP_PACKET, 16'h0000, 16'h0002, 8'h44, 32'd0, 32'd0, 8'h00);
        add_item(OP_ACTIVATE, 16'h0000, 16'h0000, 8'h00, 32'd7, 32'd1, 8'hA5);
        add_item(OP_PACKET, 16'h0000, 16'h0001, 8'h55, 32'd0, 32'd0, 8'h00);

        n_made = 0;
        while (n_made < N_RANDOM) begin
            r = $urandom_range(0, 99);
            sel = $urandom_range(0, 9);
            bytes = (sel == 0) ? 16'($urandom) : (sel == 1) ? 16'd0
                  : 16'($urandom_range(1, 1500));
            sel = $urandom_range(0, 9);
            bucket = (sel == 0) ? $urandom : (sel == 1) ? 32'd0
                   : (sel == 2) ? 32'hFFFF_FFFF : $urandom_range(0, 40000);
            sel = $urandom_range(0, 9);
            interval = (sel == 0) ? $urandom : (sel == 1) ? 32'd0 : $urandom_range(1, 6);
            if (r < 4) begin
                add_item(OP_UNUSED, 16'($urandom), 16'($urandom), 8'($urandom), $urandom,
                         $urandom, 8'($urandom));
            end else if (r < 24) begin
                add_item(OP_TICK, 16'($urandom), 16'($urandom), 8'($urandom), $urandom,
                         $urandom, 8'($urandom));
                n_made++;
            end else if (r < 40) begin
                flow = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                     : pool[$urandom_range(0, POOL_N - 1)];
                add_item(OP_ACTIVATE, flow, 16'($urandom), 8'($urandom), bucket, interval,
                         8'($urandom));
                n_made++;
            end else begin
                flow = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                     : pool[$urandom_range(0, POOL_N - 1)];
                add_item(OP_PACKET, flow, bytes, 8'($urandom), $urandom, $urandom,
                         8'($urandom));
                n_made++;
            end
        end
        n_total = offer_q.size();

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (n_sent != n_total) @(posedge i_clk);
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (2 * NUM_FLOWS + 8) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("tb_per_flow_token_bucket_policer passed");
        end else begin
            $display("tb_per_flow_token_bucket_policer failed");
        end
        $finish;
    end

    initial begin : watchdog
        #(4_000_000);
        $display("tb_per_flow_token_bucket_policer failed");
        $finish;
    end

endmodule

[filelist.f]
rtl/core/pfp_pkg.sv
rtl/core/pfp_cam.sv
rtl/core/per_flow_token_bucket_policer.sv
tb/sv/tb_per_flow_token_bucket_policer.sv
